FILE: design/bafe_pkg.sv
// package: shared types and constants of the beacon field extractor
package bafe_pkg;

  localparam int ID_BYTES    = 16;
  localparam int MIN_PAYLOAD = 24;
  localparam int PAY_IDX_W   = $clog2(MIN_PAYLOAD);

  localparam logic [7:0]  MFG_TYPE          = 8'hFF;
  localparam logic [7:0]  MIN_MFG_LEN       = 8'd3;
  localparam logic [7:0]  CODE_BYTES        = 8'd2;
  localparam logic [7:0]  TYPE_OFF          = 8'd1;
  localparam logic [7:0]  COMPANY_LO_OFF    = 8'd2;
  localparam logic [7:0]  COMPANY_HI_OFF    = 8'd3;
  localparam logic [7:0]  PAYLOAD_OFF       = 8'd4;
  localparam logic [7:0]  LAST_POSITION     = 8'hFF;
  localparam logic [15:0] COMPANY_ID_RESET  = 16'h0118;
  localparam logic [15:0] BEACON_CODE_RESET = 16'hBEAC;

  typedef enum logic [0:0] {
    CFG_COMPANY_ID  = 1'b0,
    CFG_BEACON_CODE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] company_id;
    logic [15:0] beacon_code;
  } cfg_t;

  typedef logic [MIN_PAYLOAD-1:0][7:0] payload_t;

  typedef struct packed {
    logic       done;
    logic       locked;
    logic [7:0] length;
  } walk_t;

endpackage

FILE: design/bafe_if.sv
// interfaces: byte input channel and result output channel
interface bafe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface bafe_out_if;
  logic              valid;
  logic              ready;
  logic              found;
  logic              code_match;
  logic              valid_res;
  logic [63:0]       id_upper;
  logic [63:0]       id_lower;
  logic signed [7:0] ref_rssi;
  logic [7:0]        reserved_byte;
  logic [15:0]       major;
  logic [15:0]       minor;

  modport source (output valid, output found, output code_match, output valid_res,
                  output id_upper, output id_lower, output ref_rssi,
                  output reserved_byte, output major, output minor, input ready);
  modport sink (input valid, input found, input code_match, input valid_res,
                input id_upper, input id_lower, input ref_rssi,
                input reserved_byte, input major, input minor, output ready);
endinterface

FILE: design/bafe_cfg_regs.sv
// configuration registers: company id and beacon code
module bafe_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  bafe_pkg::cfg_reg_e cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  output bafe_pkg::cfg_t    cfg_o
);
  import bafe_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COMPANY_ID:  cfg_d.company_id  = cfg_data_i;
        CFG_BEACON_CODE: cfg_d.beacon_code = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.company_id  <= COMPANY_ID_RESET;
      cfg_q.beacon_code <= BEACON_CODE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

FILE: design/bafe_walker.sv
// structure walker: tracks length-type-data headers and captures the payload
module bafe_walker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_i,
  input  logic [15:0]        company_id_i,
  output bafe_pkg::walk_t    walk_o,
  output bafe_pkg::payload_t payload_o
);
  import bafe_pkg::*;

  logic [7:0] pos_d, pos_q;
  logic [8:0] nss_d, nss_q;
  logic [7:0] len_d, len_q;
  logic [7:0] type_d, type_q;
  logic [7:0] low_d, low_q;
  logic       stop_d, stop_q;
  logic       lock_d, lock_q;
  payload_t   pay_d, pay_q;

  logic [7:0] w_len, w_type, w_low;
  logic [8:0] w_nss;
  logic       w_stop, w_lock;
  logic [7:0] off;
  logic [7:0] pidx;
  logic       pwrite;

  assign off    = pos_q - nss_q[7:0];
  assign pidx   = off - PAYLOAD_OFF;
  assign pwrite = (off >= PAYLOAD_OFF) && (pidx < 8'(MIN_PAYLOAD)) && (type_q == MFG_TYPE);

  // walk of one byte
  always_comb begin
    w_len  = len_q;
    w_type = type_q;
    w_low  = low_q;
    w_nss  = nss_q;
    w_stop = stop_q;
    w_lock = lock_q;
    pay_d  = pay_q;
    if (fire_i && !stop_q && !lock_q) begin
      if ({1'b0, pos_q} == nss_q) begin
        if (data_byte_i == 8'd0) begin
          w_stop = 1'b1;
        end else begin
          w_len  = data_byte_i;
          w_type = 8'd0;
        end
      end else if ({1'b0, pos_q} > nss_q) begin
        if (off == TYPE_OFF) begin
          w_type = data_byte_i;
        end else if (off == COMPANY_LO_OFF) begin
          w_low = data_byte_i;
        end else if (off == COMPANY_HI_OFF) begin
          if (type_q == MFG_TYPE && {data_byte_i, low_q} != company_id_i) w_type = 8'd0;
        end else if (pwrite) begin
          for (int i = 0; i < MIN_PAYLOAD; i++) begin
            if (pidx[PAY_IDX_W-1:0] == PAY_IDX_W'(i)) pay_d[i] = data_byte_i;
          end
        end
        if (off == len_q) begin
          if (w_type == MFG_TYPE && len_q >= MIN_MFG_LEN) w_lock = 1'b1;
          else w_nss = nss_q + {1'b0, len_q} + 9'd1;
        end
      end
    end
  end

  // position advance and end of packet clear
  always_comb begin
    pos_d  = pos_q;
    nss_d  = w_nss;
    len_d  = w_len;
    type_d = w_type;
    low_d  = w_low;
    stop_d = w_stop;
    lock_d = w_lock;
    if (fire_i) begin
      if (last_i) begin
        pos_d  = 8'd0;
        nss_d  = 9'd0;
        len_d  = 8'd0;
        type_d = 8'd0;
        low_d  = 8'd0;
        stop_d = 1'b0;
        lock_d = 1'b0;
      end else if (pos_q == LAST_POSITION) begin
        stop_d = 1'b1;
      end else begin
        pos_d = pos_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 8'd0;
      nss_q  <= 9'd0;
      len_q  <= 8'd0;
      type_q <= 8'd0;
      low_q  <= 8'd0;
      stop_q <= 1'b0;
      lock_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      nss_q  <= nss_d;
      len_q  <= len_d;
      type_q <= type_d;
      low_q  <= low_d;
      stop_q <= stop_d;
      lock_q <= lock_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  assign walk_o.done   = fire_i && last_i;
  assign walk_o.locked = w_lock;
  assign walk_o.length = w_len;
  assign payload_o     = pay_d;
endmodule

FILE: design/bafe_result.sv
// result decode and output register
module bafe_result (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bafe_pkg::walk_t    walk_i,
  input  bafe_pkg::payload_t payload_i,
  input  logic [15:0]        beacon_code_i,
  output logic               in_ready_o,
  bafe_out_if.source         out_o
);
  import bafe_pkg::*;

  logic [7:0] plen;
  logic       code_ok, valid_ok;
  logic       ovalid_d, ovalid_q;

  logic              found_q, code_q, vres_q;
  logic [63:0]       idu_d, idu_q, idl_d, idl_q;
  logic signed [7:0] rssi_d, rssi_q;
  logic [7:0]        rsv_d, rsv_q;
  logic [15:0]       major_d, major_q, minor_d, minor_q;

  assign plen     = (walk_i.length >= MIN_MFG_LEN) ? walk_i.length - MIN_MFG_LEN : 8'd0;
  assign code_ok  = walk_i.locked && (plen >= CODE_BYTES) &&
                    ({payload_i[0], payload_i[1]} == beacon_code_i);
  assign valid_ok = code_ok && (plen >= 8'(MIN_PAYLOAD));

  always_comb begin
    idu_d   = '0;
    idl_d   = '0;
    rssi_d  = '0;
    rsv_d   = '0;
    major_d = '0;
    minor_d = '0;
    if (valid_ok) begin
      for (int i = 0; i < ID_BYTES / 2; i++) begin
        idu_d[63 - 8*i -: 8] = payload_i[2 + i];
        idl_d[63 - 8*i -: 8] = payload_i[2 + ID_BYTES / 2 + i];
      end
      rssi_d  = signed'(payload_i[2 + ID_BYTES]);
      rsv_d   = payload_i[3 + ID_BYTES];
      major_d = {payload_i[4 + ID_BYTES], payload_i[5 + ID_BYTES]};
      minor_d = {payload_i[6 + ID_BYTES], payload_i[7 + ID_BYTES]};
    end
  end

  assign in_ready_o = !ovalid_q || out_o.ready;

  always_comb begin
    ovalid_d = ovalid_q;
    if (walk_i.done) ovalid_d = 1'b1;
    else if (out_o.ready) ovalid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (walk_i.done) begin
      found_q <= walk_i.locked;
      code_q  <= code_ok;
      vres_q  <= valid_ok;
      idu_q   <= idu_d;
      idl_q   <= idl_d;
      rssi_q  <= rssi_d;
      rsv_q   <= rsv_d;
      major_q <= major_d;
      minor_q <= minor_d;
    end
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.found         = found_q;
  assign out_o.code_match    = code_q;
  assign out_o.valid_res     = vres_q;
  assign out_o.id_upper      = idu_q;
  assign out_o.id_lower      = idl_q;
  assign out_o.ref_rssi      = rssi_q;
  assign out_o.reserved_byte = rsv_q;
  assign out_o.major         = major_q;
  assign out_o.minor         = minor_q;
endmodule

FILE: design/ble_ad_beacon_field_extractor.sv
// top level: beacon field extractor for byte-serial advertisements
//
// Advertisement bytes enter on in_i (data_byte, last), one transfer per byte.
// Each byte is walked in the cycle it is accepted; the length-type-data chain
// is tracked and the payload of the first manufacturer structure whose
// company id matches is captured. The byte with last set produces exactly one
// result transfer on out_o, registered, in the cycle after its acceptance.
// Throughput is one byte per cycle while in_i.ready is high; it is set by the
// walker registers being updated once per accepted byte, with the result
// register holding only the decoded fields of the finished packet.
// When out_o stalls the result is held in the output register; in_i.ready
// stays high while that register is empty or is being taken in the same cycle.
// Configuration writes (company id at index 0, beacon code at index 1) take
// effect at the next edge and must only be issued while the block is idle.
// Reset clears the walk state and the output valid and loads the default
// company id and beacon code.
module ble_ad_beacon_field_extractor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  bafe_pkg::cfg_reg_e cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  bafe_in_if.sink            in_i,
  bafe_out_if.source         out_o
);
  import bafe_pkg::*;

  cfg_t     cfg;
  walk_t    walk;
  payload_t payload;
  logic     in_ready;
  logic     fire;

  assign in_i.ready = in_ready;
  assign fire       = in_i.valid && in_ready;

  bafe_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bafe_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .data_byte_i  (in_i.data_byte),
    .last_i       (in_i.last),
    .company_id_i (cfg.company_id),
    .walk_o       (walk),
    .payload_o    (payload)
  );

  bafe_result u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .walk_i        (walk),
    .payload_i     (payload),
    .beacon_code_i (cfg.beacon_code),
    .in_ready_o    (in_ready),
    .out_o         (out_o)
  );
endmodule

FILE: design/bafe_checker.sv
// checker: port level properties of the beacon field extractor, with bind
module bafe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        found_i,
  input logic        code_match_i,
  input logic        valid_res_i,
  input logic [63:0] id_upper_i,
  input logic [63:0] id_lower_i,
  input logic [7:0]  ref_rssi_i,
  input logic [7:0]  reserved_byte_i,
  input logic [15:0] major_i,
  input logic [15:0] minor_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_flag_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (!code_match_i || found_i) && (!valid_res_i || code_match_i))
    else $error("result flags inconsistent");

  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !valid_res_i |-> id_upper_i == 64'd0 && id_lower_i == 64'd0 &&
      ref_rssi_i == 8'd0 && reserved_byte_i == 8'd0 && major_i == 16'd0 && minor_i == 16'd0)
    else $error("fields set without a valid beacon");

  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i))
    else $error("result without a last byte transfer");

endmodule

bind ble_ad_beacon_field_extractor bafe_checker u_bafe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_last_i       (in_i.last),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .found_i         (out_o.found),
  .code_match_i    (out_o.code_match),
  .valid_res_i     (out_o.valid_res),
  .id_upper_i      (out_o.id_upper),
  .id_lower_i      (out_o.id_lower),
  .ref_rssi_i      (out_o.ref_rssi),
  .reserved_byte_i (out_o.reserved_byte),
  .major_i         (out_o.major),
  .minor_i         (out_o.minor)
);

FILE: verif/tb_top.sv
// testbench: directed packet table and random advertisements checked against a walk predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bafe_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int PHASE_BYTES = 40;
  localparam int PHASE_RESULTS = 1;
  localparam int LONG_PKT = 300;

  typedef enum logic [3:0] {
    PK_LAST_ONLY, PK_BEACON, PK_CODE_BAD, PK_COMPANY_BAD, PK_SHORT_MFG, PK_ZERO_LEN,
    PK_TRUNC, PK_LONG_LOCK, PK_LONG_NOLOCK, PK_OTHER_FIRST, PK_NOISE, PK_MIXED
  } pkt_kind_e;

  typedef enum logic [1:0] {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_e;

  typedef struct packed {
    logic              found;
    logic              code_match;
    logic              valid_res;
    logic [63:0]       id_upper;
    logic [63:0]       id_lower;
    logic signed [7:0] ref_rssi;
    logic [7:0]        reserved_byte;
    logic [15:0]       major;
    logic [15:0]       minor;
  } beacon_res_t;

  typedef struct packed {
    pkt_kind_e  kind;
    logic [7:0] pay_len;
    fill_e      fill;
    logic       typed;
    logic       e_found;
    logic       e_code;
    logic       e_valid;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [18] = '{
    '{PK_LAST_ONLY,   8'd0,  FILL_RANDOM, 1'b1, 1'b0, 1'b0, 1'b0},
    '{PK_BEACON,      8'd24, FILL_ONES,   1'b1, 1'b1, 1'b1, 1'b1},
    '{PK_BEACON,      8'd24, FILL_ZEROS,  1'b1, 1'b1, 1'b1, 1'b1},
    '{PK_BEACON,      8'd24, FILL_RANDOM, 1'b0, 1'b0, 1'b0, 1'b0},
    '{PK_BEACON,      8'd40, FILL_RANDOM, 1'b0, 1'b0, 1'b0, 1'b0},
    '{PK_BEACON,      8'd0,  FILL_RANDOM, 1'b1, 1'b1, 1'b0, 1'b0},
    '{PK_BEACON,      8'd1,  FILL_RANDOM, 1'b1, 1'b1, 1'b0, 1'b0},
    '{PK_BEACON,      8'd2,  FILL_RANDOM, 1'b1, 1'b1, 1'b1, 1'b0},
    '{PK_BEACON,      8'd23, FILL_ONES,   1'b1, 1'b1, 1'b1, 1'b0},
    '{PK_CODE_BAD,    8'd24, FILL_RANDOM, 1'b1, 1'b1, 1'b0, 1'b0},
    '{PK_COMPANY_BAD, 8'd24, FILL_RANDOM, 1'b0, 1'b0, 1'b0, 1'b0},
    '{PK_SHORT_MFG,   8'd2,  FILL_RANDOM, 1'b1, 1'b0, 1'b0, 1'b0},
    '{PK_ZERO_LEN,    8'd24, FILL_RANDOM, 1'b1, 1'b0, 1'b0, 1'b0},
    '{PK_TRUNC,       8'd24, FILL_RANDOM, 1'b1, 1'b0, 1'b0, 1'b0},
    '{PK_OTHER_FIRST, 8'd24, FILL_RANDOM, 1'b0, 1'b0, 1'b0, 1'b0},
    '{PK_LONG_LOCK,   8'd24, FILL_ONES,   1'b0, 1'b0, 1'b0, 1'b0},
    '{PK_LONG_NOLOCK, 8'd24, FILL_RANDOM, 1'b0, 1'b0, 1'b0, 1'b0},
    '{PK_NOISE,       8'd0,  FILL_RANDOM, 1'b0, 1'b0, 1'b0, 1'b0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_reg_e    cfg_idx_i;
  logic [15:0] cfg_data_i;

  bafe_in_if  in_if ();
  bafe_out_if out_if ();

  ble_ad_beacon_field_extractor u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor copy of the walk and the registers
  logic [15:0] cfg_company;
  logic [15:0] cfg_code;
  logic [7:0]  pos_q;
  logic [8:0]  seg_start;
  logic [7:0]  seg_len;
  logic [7:0]  seg_type;
  logic [7:0]  cid_lo;
  bit          walk_done;
  bit          walk_locked;
  logic [7:0]  pay_buf [MIN_PAYLOAD];

  beacon_res_t beacon_exp_q [$];
  logic [7:0]  pkt_q [$];
  beacon_res_t typed_res;
  bit          typed_pending;
  int          err_count;
  int          idle_cycles;
  int          res_seen;
  int          bytes_sent;
  int          burst_left;

  task automatic clear_walk();
    pos_q = '0;
    seg_start = '0;
    seg_len = '0;
    seg_type = '0;
    cid_lo = '0;
    walk_done = 1'b0;
    walk_locked = 1'b0;
    foreach (pay_buf[i]) pay_buf[i] = '0;
  endtask

  task automatic walk_adv_byte(input logic [7:0] b);
    logic [8:0] off;
    int         idx;
    if (!(walk_done || walk_locked)) begin
      if ({1'b0, pos_q} == seg_start) begin
        if (b == 8'd0) begin
          walk_done = 1'b1;
        end else begin
          seg_len = b;
          seg_type = '0;
        end
      end else if ({1'b0, pos_q} > seg_start) begin
        off = {1'b0, pos_q} - seg_start;
        idx = int'(off) - int'(PAYLOAD_OFF);
        if (off == TYPE_OFF) begin
          seg_type = b;
        end else if (off == COMPANY_LO_OFF) begin
          cid_lo = b;
        end else if (off == COMPANY_HI_OFF) begin
          if (seg_type == MFG_TYPE && {b, cid_lo} != cfg_company) seg_type = '0;
        end else if (seg_type == MFG_TYPE && idx < MIN_PAYLOAD) begin
          pay_buf[idx] = b;
        end
        if (off == {1'b0, seg_len}) begin
          if (seg_type == MFG_TYPE && seg_len >= MIN_MFG_LEN) walk_locked = 1'b1;
          else seg_start = seg_start + {1'b0, seg_len} + 9'd1;
        end
      end
    end
  endtask

  task automatic track_adv_byte(input logic [7:0] b, input logic l,
                                output bit has, output beacon_res_t res);
    logic [7:0] plen;
    walk_adv_byte(b);
    res = '0;
    has = l;
    if (!l) begin
      if (pos_q >= LAST_POSITION) walk_done = 1'b1;
      else pos_q = pos_q + 8'd1;
    end else begin
      plen = (seg_len >= MIN_MFG_LEN) ? seg_len - MIN_MFG_LEN : 8'd0;
      res.found = walk_locked;
      res.code_match = walk_locked && plen >= CODE_BYTES && {pay_buf[0], pay_buf[1]} == cfg_code;
      res.valid_res = res.code_match && plen >= MIN_PAYLOAD;
      if (res.valid_res) begin
        for (int i = 0; i < ID_BYTES / 2; i++) begin
          res.id_upper = {res.id_upper[55:0], pay_buf[2 + i]};
          res.id_lower = {res.id_lower[55:0], pay_buf[2 + ID_BYTES / 2 + i]};
        end
        res.ref_rssi = pay_buf[2 + ID_BYTES];
        res.reserved_byte = pay_buf[3 + ID_BYTES];
        res.major = {pay_buf[4 + ID_BYTES], pay_buf[5 + ID_BYTES]};
        res.minor = {pay_buf[6 + ID_BYTES], pay_buf[7 + ID_BYTES]};
      end
      clear_walk();
    end
  endtask

  task automatic add_other(input int len);
    pkt_q.push_back(8'(len));
    pkt_q.push_back(8'($urandom_range(0, 254)));
    repeat (len - 1) pkt_q.push_back(8'($urandom));
  endtask

  task automatic add_beacon(input logic [15:0] cid, input logic [15:0] code,
                            input int pay_len, input fill_e fill);
    logic [7:0] fb;
    pkt_q.push_back(8'(pay_len + 3));
    pkt_q.push_back(MFG_TYPE);
    pkt_q.push_back(cid[7:0]);
    pkt_q.push_back(cid[15:8]);
    for (int i = 0; i < pay_len; i++) begin
      case (fill)
        FILL_ONES:  fb = 8'hFF;
        FILL_ZEROS: fb = 8'h00;
        default:    fb = 8'($urandom);
      endcase
      if (i == 0) fb = code[15:8];
      else if (i == 1) fb = code[7:0];
      pkt_q.push_back(fb);
    end
  endtask

  task automatic build_packet(input pkt_kind_e kind, input logic [7:0] pay_len,
                              input fill_e fill);
    logic [15:0] cid;
    logic [15:0] code;
    case (kind)
      PK_LAST_ONLY: pkt_q.push_back(8'h00);
      PK_BEACON: add_beacon(cfg_company, cfg_code, pay_len, fill);
      PK_CODE_BAD: add_beacon(cfg_company, cfg_code ^ 16'h0001, pay_len, fill);
      PK_COMPANY_BAD: begin
        add_beacon(cfg_company ^ 16'h0100, cfg_code, pay_len, fill);
        add_beacon(cfg_company, cfg_code, pay_len, fill);
      end
      PK_SHORT_MFG: begin
        pkt_q.push_back(pay_len);
        pkt_q.push_back(MFG_TYPE);
        if (pay_len > 8'd1) pkt_q.push_back(cfg_company[7:0]);
        pkt_q.push_back(cfg_company[15:8]);
      end
      PK_ZERO_LEN: begin
        pkt_q.push_back(8'h00);
        add_beacon(cfg_company, cfg_code, pay_len, fill);
      end
      PK_TRUNC: begin
        add_beacon(cfg_company, cfg_code, pay_len, fill);
        void'(pkt_q.pop_back());
      end
      PK_LONG_LOCK: begin
        add_beacon(cfg_company, cfg_code, pay_len, fill);
        while (pkt_q.size() < LONG_PKT) add_other(20);
        while (pkt_q.size() > LONG_PKT) void'(pkt_q.pop_back());
      end
      PK_LONG_NOLOCK: begin
        while (pkt_q.size() < 240) add_other($urandom_range(30, 60));
        add_beacon(cfg_company, cfg_code, MIN_PAYLOAD, fill);
      end
      PK_OTHER_FIRST: begin
        repeat ($urandom_range(1, 3)) add_other($urandom_range(1, 10));
        add_beacon(cfg_company, cfg_code, pay_len, fill);
      end
      PK_NOISE: repeat ($urandom_range(1, 40)) pkt_q.push_back(8'($urandom));
      default: begin
        repeat ($urandom_range(0, 2)) add_other($urandom_range(1, 12));
        cid = ($urandom_range(0, 9) != 0) ? cfg_company : 16'($urandom);
        code = ($urandom_range(0, 6) != 0) ? cfg_code : 16'($urandom);
        add_beacon(cid, code, pay_len, fill);
        if ($urandom_range(0, 1) == 1) add_other($urandom_range(1, 12));
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 3)) if (pkt_q.size() > 1) void'(pkt_q.pop_back());
        end
      end
    endcase
  endtask

  task automatic gen_random_packet();
    int          r;
    int          plen;
    fill_e       f;
    pkt_kind_e   k;
    r = $urandom_range(0, 99);
    plen = ($urandom_range(0, 9) < 7) ? $urandom_range(24, 27) : $urandom_range(0, 40);
    f = fill_e'($urandom_range(0, 2));
    if (r < 65) k = PK_MIXED;
    else if (r < 75) k = PK_NOISE;
    else if (r < 80) k = PK_OTHER_FIRST;
    else if (r < 85) k = PK_COMPANY_BAD;
    else if (r < 89) k = PK_ZERO_LEN;
    else if (r < 93) k = PK_SHORT_MFG;
    else if (r < 96) k = PK_TRUNC;
    else if (r < 98) k = PK_CODE_BAD;
    else if (r < 99) k = PK_LONG_LOCK;
    else k = PK_LONG_NOLOCK;
    if (k == PK_SHORT_MFG) plen = $urandom_range(1, 2);
    build_packet(k, 8'(plen), f);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l, input bit steady);
    bit          has;
    beacon_res_t res;
    if (!steady && burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.last <= l;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
    track_adv_byte(b, l, has, res);
    if (has) begin
      if (typed_pending) beacon_exp_q.push_back(typed_res);
      else beacon_exp_q.push_back(res);
      typed_pending = 1'b0;
    end
  endtask

  task automatic send_packet();
    bit steady;
    int n;
    steady = ($urandom_range(0, 3) == 0);
    n = pkt_q.size();
    for (int k = 0; k < n; k++) send_byte(pkt_q[k], k == n - 1, steady);
    pkt_q.delete();
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (beacon_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg_pair(input logic [15:0] cid, input logic [15:0] code);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_COMPANY_ID;
    cfg_data_i <= cid;
    @(posedge clk_i);
    cfg_idx_i <= CFG_BEACON_CODE;
    cfg_data_i <= code;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_company = cid;
    cfg_code = code;
  endtask

  task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // output side: result transfers checked in order, idle cycles counted
  always @(posedge clk_i) begin
    beacon_res_t want;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (out_if.valid && out_if.ready) begin
        res_seen++;
        if (beacon_exp_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result transfer, expected none actual found=%0b",
                   $time, out_if.found);
        end else begin
          want = beacon_exp_q.pop_front();
          cmp_field("found", want.found, out_if.found);
          cmp_field("code_match", want.code_match, out_if.code_match);
          cmp_field("valid_res", want.valid_res, out_if.valid_res);
          cmp_field("id_upper", want.id_upper, out_if.id_upper);
          cmp_field("id_lower", want.id_lower, out_if.id_lower);
          cmp_field("ref_rssi", 64'(unsigned'(want.ref_rssi)), 64'(unsigned'(out_if.ref_rssi)));
          cmp_field("reserved_byte", want.reserved_byte, out_if.reserved_byte);
          cmp_field("major", want.major, out_if.major);
          cmp_field("minor", want.minor, out_if.minor);
        end
      end
    end
  end

  initial begin
    int span;
    int stall_mode;
    out_if.ready = 1'b0;
    forever begin
      stall_mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      for (int k = 0; k < span; k++) begin
        @(posedge clk_i);
        case (stall_mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= (k % 6 != 5);
          default: out_if.ready <= ($urandom_range(0, 11) == 0);
        endcase
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int start_bytes;
    int start_res;
    dir_row_t row;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_COMPANY_ID;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.last = 1'b0;
    cfg_company = COMPANY_ID_RESET;
    cfg_code = BEACON_CODE_RESET;
    err_count = 0;
    idle_cycles = 0;
    res_seen = 0;
    bytes_sent = 0;
    burst_left = 0;
    typed_pending = 1'b0;
    clear_walk();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[r]) begin
      row = DIR_ROWS[r];
      build_packet(row.kind, row.pay_len, row.fill);
      if (row.typed) begin
        typed_res = '0;
        typed_res.found = row.e_found;
        typed_res.code_match = row.e_code;
        typed_res.valid_res = row.e_valid;
        if (row.e_valid && row.fill == FILL_ONES) begin
          typed_res.id_upper = '1;
          typed_res.id_lower = '1;
          typed_res.ref_rssi = -8'sd1;
          typed_res.reserved_byte = '1;
          typed_res.major = '1;
          typed_res.minor = '1;
        end
        typed_pending = 1'b1;
      end
      send_packet();
    end

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: write_cfg_pair(16'h0000, 16'h0000);
        1: write_cfg_pair(16'hFFFF, 16'hFFFF);
        2: write_cfg_pair(16'($urandom), 16'($urandom));
        default: write_cfg_pair(COMPANY_ID_RESET, 16'($urandom));
      endcase
      start_bytes = bytes_sent;
      start_res = res_seen;
      while (bytes_sent - start_bytes < PHASE_BYTES || res_seen - start_res < PHASE_RESULTS) begin
        gen_random_packet();
        send_packet();
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: ble_ad_beacon_field_extractor.f
design/bafe_pkg.sv
design/bafe_if.sv
design/bafe_cfg_regs.sv
design/bafe_walker.sv
design/bafe_result.sv
design/ble_ad_beacon_field_extractor.sv
design/bafe_checker.sv
verif/tb_top.sv
